>>> rtl/core/stcu_pkg.sv
`timescale 1ns / 1ps

package stcu_pkg;

   localparam int MaxChannels   = 4;
   localparam int DataWidth     = 32;
   localparam int OpWidth       = 2;
   localparam int IdxWidth      = 4;
   localparam int ChWidth       = 2;
   localparam int PrescaleWidth = 8;
   localparam int PrescaleLsb   = 8;

   localparam logic [OpWidth-1:0] OpTick  = 2'd0;
   localparam logic [OpWidth-1:0] OpRead  = 2'd1;
   localparam logic [OpWidth-1:0] OpWrite = 2'd2;

   localparam int RegControl       = 0;
   localparam int RegCounter       = 1;
   localparam int RegChannelBase   = 2;
   localparam int ChannelStride    = 3;
   localparam int OffsetEnable     = 0;
   localparam int OffsetFlag       = 1;
   localparam int OffsetCompare    = 2;

   typedef enum logic [2:0] {
      KIND_NONE,
      KIND_CONTROL,
      KIND_COUNTER,
      KIND_ENABLE,
      KIND_FLAG,
      KIND_COMPARE
   } reg_kind_type;

   typedef struct packed {
      reg_kind_type       kind;
      logic [ChWidth-1:0] ch;
   } reg_decode_type;

   typedef struct packed {
      logic [OpWidth-1:0]   op;
      logic [IdxWidth-1:0]  reg_index;
      logic [DataWidth-1:0] write_data;
   } item_type;

   typedef struct packed {
      logic [DataWidth-1:0]   read_data;
      logic [MaxChannels-1:0] flags;
   } rsp_type;

   function automatic reg_decode_type decode_index(input logic [IdxWidth-1:0] idx);
      reg_decode_type d;
      int base;
      d.kind = KIND_NONE;
      d.ch   = '0;
      if (int'(idx) == RegControl) begin
         d.kind = KIND_CONTROL;
      end else if (int'(idx) == RegCounter) begin
         d.kind = KIND_COUNTER;
      end
      for (int n = 0; n < MaxChannels; n++) begin
         base = RegChannelBase + ChannelStride * n;
         if (int'(idx) == base + OffsetEnable) begin
            d.kind = KIND_ENABLE;
            d.ch   = ChWidth'(n);
         end else if (int'(idx) == base + OffsetFlag) begin
            d.kind = KIND_FLAG;
            d.ch   = ChWidth'(n);
         end else if (int'(idx) == base + OffsetCompare) begin
            d.kind = KIND_COMPARE;
            d.ch   = ChWidth'(n);
         end
      end
      return d;
   endfunction

endpackage

>>> rtl/core/system_timer_four_compare_unit.sv
`timescale 1ns / 1ps
// path: a req transaction passes the input register, then the result register, and then
// shows as rsp valid; a low rsp_ready holds it in the result register
// throughput: one transaction per cycle while rsp_ready stays high
// the result register frees a slot whenever its transaction is taken, so both stages flow
// reset: synchronous, active high; clears control, counter, prescaler, enables,
// compare values and flags, and empties both stages

module system_timer_four_compare_unit #(
   parameter int CHANNELS = stcu_pkg::MaxChannels
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [stcu_pkg::OpWidth-1:0]       req_op,
   input  logic [stcu_pkg::IdxWidth-1:0]      req_reg_index,
   input  logic [stcu_pkg::DataWidth-1:0]     req_write_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [stcu_pkg::DataWidth-1:0]     rsp_read_data,
   output logic                               rsp_irq,
   output logic [stcu_pkg::MaxChannels-1:0]   rsp_channel_flags
);

   logic                               in_valid_ff;
   stcu_pkg::item_type                 in_item_ff;
   logic                               out_valid_ff;
   logic [stcu_pkg::DataWidth-1:0]     out_read_data_ff;
   logic                               out_irq_ff;
   logic [stcu_pkg::MaxChannels-1:0]   out_flags_ff;
   stcu_pkg::rsp_type                  core_rsp;
   logic                               out_free;
   logic                               fire;

   assign out_free  = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || out_free;

   stcu_core #(
      .CHANNELS(CHANNELS)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .fire (fire),
      .item (in_item_ff),
      .rsp  (core_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_item_ff.op         <= req_op;
         in_item_ff.reg_index  <= req_reg_index;
         in_item_ff.write_data <= req_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_read_data_ff <= core_rsp.read_data;
         out_irq_ff       <= |core_rsp.flags;
         out_flags_ff     <= core_rsp.flags;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_read_data     = out_read_data_ff;
   assign rsp_irq           = out_irq_ff;
   assign rsp_channel_flags = out_flags_ff;

   // interrupt follows the flags of the same transaction
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_irq == (|rsp_channel_flags))
      else $error("irq does not match channel flags");

   // a pending result is never overwritten
   assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> $stable(out_read_data_ff) && $stable(out_flags_ff))
      else $error("pending result overwritten");

   // the input stage never drops a transaction
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_item_ff))
      else $error("input stage lost a transaction");

endmodule

>>> rtl/core/stcu_core.sv
`timescale 1ns / 1ps

module stcu_core #(
   parameter int CHANNELS = stcu_pkg::MaxChannels
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  stcu_pkg::item_type item,
   output stcu_pkg::rsp_type  rsp
);

   logic [stcu_pkg::DataWidth-1:0]     control_ff, control_in;
   logic [stcu_pkg::DataWidth-1:0]     count_ff, count_in;
   logic [stcu_pkg::PrescaleWidth-1:0] prescale_ff, prescale_in;
   logic [CHANNELS-1:0]                enable_ff, enable_in;
   logic [CHANNELS-1:0]                flag_ff, flag_in;
   logic [stcu_pkg::DataWidth-1:0]     compare_ff [CHANNELS];
   logic [stcu_pkg::DataWidth-1:0]     compare_in [CHANNELS];

   stcu_pkg::reg_decode_type           dec;
   logic                               is_tick, is_read, is_write;
   logic                               step;
   logic [stcu_pkg::PrescaleWidth-1:0] limit;
   logic [stcu_pkg::DataWidth-1:0]     count_inc;
   logic [stcu_pkg::DataWidth-1:0]     read_data;
   logic [CHANNELS-1:0]                hit;

   always_comb begin
      dec       = stcu_pkg::decode_index(item.reg_index);
      is_tick   = (item.op == stcu_pkg::OpTick);
      is_read   = (item.op == stcu_pkg::OpRead);
      is_write  = (item.op == stcu_pkg::OpWrite);
      limit     = control_ff[stcu_pkg::PrescaleLsb +: stcu_pkg::PrescaleWidth];
      count_inc = count_ff + 1'b1;
      step      = is_tick && control_ff[0] && (prescale_ff >= limit);

      control_in  = control_ff;
      count_in    = count_ff;
      prescale_in = prescale_ff;
      enable_in   = enable_ff;
      flag_in     = flag_ff;
      read_data   = '0;

      // tick
      if (is_tick && control_ff[0]) begin
         if (step) begin
            prescale_in = '0;
            count_in    = count_inc;
         end else begin
            prescale_in = prescale_ff + 1'b1;
         end
      end

      // register access
      case (dec.kind)
         stcu_pkg::KIND_CONTROL: begin
            if (is_write) control_in = item.write_data;
            if (is_read) read_data = control_ff;
         end
         stcu_pkg::KIND_COUNTER: begin
            if (is_write) count_in = item.write_data;
            if (is_read) read_data = count_ff;
         end
         default: begin
         end
      endcase

      for (int n = 0; n < CHANNELS; n++) begin
         hit[n]        = (dec.ch == stcu_pkg::ChWidth'(n));
         compare_in[n] = compare_ff[n];
         if (step && enable_ff[n] && (compare_ff[n] == count_inc)) begin
            flag_in[n] = 1'b1;
         end
         if (hit[n]) begin
            case (dec.kind)
               stcu_pkg::KIND_ENABLE: begin
                  if (is_write) enable_in[n] = item.write_data[0];
                  if (is_read) read_data = {{(stcu_pkg::DataWidth-1){1'b0}}, enable_ff[n]};
               end
               stcu_pkg::KIND_FLAG: begin
                  if (is_write && item.write_data[0]) flag_in[n] = 1'b0;
                  if (is_read) read_data = {{(stcu_pkg::DataWidth-1){1'b0}}, flag_ff[n]};
               end
               stcu_pkg::KIND_COMPARE: begin
                  if (is_write) compare_in[n] = item.write_data;
                  if (is_read) read_data = compare_ff[n];
               end
               default: begin
               end
            endcase
         end
      end

      rsp.read_data = read_data;
      rsp.flags     = '0;
      for (int n = 0; n < CHANNELS; n++) begin
         rsp.flags[n] = flag_in[n];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_ff  <= '0;
         count_ff    <= '0;
         prescale_ff <= '0;
         enable_ff   <= '0;
         flag_ff     <= '0;
         for (int n = 0; n < CHANNELS; n++) begin
            compare_ff[n] <= '0;
         end
      end else if (fire) begin
         control_ff  <= control_in;
         count_ff    <= count_in;
         prescale_ff <= prescale_in;
         enable_ff   <= enable_in;
         flag_ff     <= flag_in;
         for (int n = 0; n < CHANNELS; n++) begin
            compare_ff[n] <= compare_in[n];
         end
      end
   end

   // state moves only with a transaction
   assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(count_ff) && $stable(flag_ff) && $stable(prescale_ff))
      else $error("timer state changed without a transaction");

   // flags are set only by ticks
   assert property (@(posedge clock) disable iff (reset)
      fire && !is_tick |=> (flag_ff & ~$past(flag_ff)) == '0)
      else $error("flag set by a register access");

   // counting disabled holds the counter
   assert property (@(posedge clock) disable iff (reset)
      fire && is_tick && !control_ff[0] |=> $stable(count_ff) && $stable(prescale_ff))
      else $error("counter moved while disabled");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;

   localparam int CycleLimit = 500000;
   localparam int ItemTarget = 1925;

   typedef struct packed {
      logic [stcu_pkg::DataWidth-1:0]   read_data;
      logic                             irq;
      logic [stcu_pkg::MaxChannels-1:0] flags;
   } timer_result_type;

   class timer_scoreboard;
      logic [stcu_pkg::DataWidth-1:0]     ctrl_q;
      logic [stcu_pkg::DataWidth-1:0]     count_q;
      logic [stcu_pkg::PrescaleWidth-1:0] prescaler_q;
      logic [stcu_pkg::MaxChannels-1:0]   chan_en;
      logic [stcu_pkg::MaxChannels-1:0]   chan_hit;
      logic [stcu_pkg::DataWidth-1:0]     chan_cmp [stcu_pkg::MaxChannels];
      timer_result_type                   pending_results [$];
      int                                 failures;

      function new();
         ctrl_q      = '0;
         count_q     = '0;
         prescaler_q = '0;
         chan_en     = '0;
         chan_hit    = '0;
         foreach (chan_cmp[n]) chan_cmp[n] = '0;
         failures    = 0;
      endfunction

      function logic [stcu_pkg::DataWidth-1:0] reg_access(int idx, bit wr,
                                                          logic [stcu_pkg::DataWidth-1:0] data);
         int ch;
         int kind;
         if (idx == stcu_pkg::RegControl) begin
            if (wr) ctrl_q = data;
            return wr ? 32'd0 : ctrl_q;
         end
         if (idx == stcu_pkg::RegCounter) begin
            if (wr) count_q = data;
            return wr ? 32'd0 : count_q;
         end
         ch   = (idx - stcu_pkg::RegChannelBase) / stcu_pkg::ChannelStride;
         kind = (idx - stcu_pkg::RegChannelBase) % stcu_pkg::ChannelStride;
         if (ch >= stcu_pkg::MaxChannels) return 32'd0;
         case (kind)
            stcu_pkg::OffsetEnable: begin
               if (wr) chan_en[ch] = data[0];
               return wr ? 32'd0 : {31'd0, chan_en[ch]};
            end
            stcu_pkg::OffsetFlag: begin
               if (wr && data[0]) chan_hit[ch] = 1'b0;
               return wr ? 32'd0 : {31'd0, chan_hit[ch]};
            end
            default: begin
               if (wr) chan_cmp[ch] = data;
               return wr ? 32'd0 : chan_cmp[ch];
            end
         endcase
      endfunction

      function void predict_timer(logic [stcu_pkg::OpWidth-1:0] op,
                                  logic [stcu_pkg::IdxWidth-1:0] idx,
                                  logic [stcu_pkg::DataWidth-1:0] data);
         timer_result_type r;
         r.read_data = '0;
         case (op)
            stcu_pkg::OpTick: begin
               if (ctrl_q[0]) begin
                  if (prescaler_q >=
                      ctrl_q[stcu_pkg::PrescaleLsb +: stcu_pkg::PrescaleWidth]) begin
                     prescaler_q = '0;
                     count_q     = count_q + 1'b1;
                     for (int n = 0; n < stcu_pkg::MaxChannels; n++)
                        if (chan_en[n] && chan_cmp[n] == count_q) chan_hit[n] = 1'b1;
                  end else begin
                     prescaler_q = prescaler_q + 1'b1;
                  end
               end
            end
            stcu_pkg::OpRead:  r.read_data = reg_access(int'(idx), 1'b0, '0);
            stcu_pkg::OpWrite: void'(reg_access(int'(idx), 1'b1, data));
            default: ;
         endcase
         r.flags = chan_hit;
         r.irq   = |chan_hit;
         pending_results.push_back(r);
      endfunction

      function void check_timer_result(logic [stcu_pkg::DataWidth-1:0] read_data, logic irq,
                                       logic [stcu_pkg::MaxChannels-1:0] flags);
         timer_result_type e;
         if (pending_results.size() == 0) begin
            failures++;
            if (failures <= 10)
               $display("unexpected transaction: read_data=%h irq=%b flags=%b",
                        read_data, irq, flags);
            return;
         end
         e = pending_results.pop_front();
         if (read_data !== e.read_data || irq !== e.irq || flags !== e.flags) begin
            failures++;
            if (failures <= 10)
               $display("mismatch: exp read_data=%h irq=%b flags=%b, got %h %b %b",
                        e.read_data, e.irq, e.flags, read_data, irq, flags);
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_valid = 1'b0;
   logic                             req_ready;
   logic [stcu_pkg::OpWidth-1:0]     req_op = stcu_pkg::OpTick;
   logic [stcu_pkg::IdxWidth-1:0]    req_reg_index = '0;
   logic [stcu_pkg::DataWidth-1:0]   req_write_data = '0;
   logic                             rsp_valid;
   logic                             rsp_ready = 1'b0;
   logic [stcu_pkg::DataWidth-1:0]   rsp_read_data;
   logic                             rsp_irq;
   logic [stcu_pkg::MaxChannels-1:0] rsp_channel_flags;

   timer_scoreboard sb = new();
   int items_sent = 0;
   int burst_left = 0;
   int stall_mode = 0;
   int stall_left = 0;
   int cycle_count = 0;

   system_timer_four_compare_unit dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_op           (req_op),
      .req_reg_index    (req_reg_index),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_irq          (rsp_irq),
      .rsp_channel_flags(rsp_channel_flags)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // response side: stall pattern switches between modes of random length
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready)
         sb.check_timer_result(rsp_read_data, rsp_irq, rsp_channel_flags);
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(16, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= $urandom_range(0, 1);
         2: rsp_ready <= (stall_left % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   function automatic logic [stcu_pkg::IdxWidth-1:0] chan_reg(int ch, int offset);
      return stcu_pkg::IdxWidth'(stcu_pkg::RegChannelBase + stcu_pkg::ChannelStride * ch
                                 + offset);
   endfunction

   task automatic send_item(input logic [stcu_pkg::OpWidth-1:0] op,
                            input logic [stcu_pkg::IdxWidth-1:0] idx,
                            input logic [stcu_pkg::DataWidth-1:0] data);
      int gap;
      req_valid      <= 1'b1;
      req_op         <= op;
      req_reg_index  <= idx;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      sb.predict_timer(op, idx, data);
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(0, 12);
      end
   endtask

   task automatic random_read();
      send_item(stcu_pkg::OpRead, stcu_pkg::IdxWidth'($urandom_range(0, 15)), $urandom);
   endtask

   // program a channel one to four counts ahead, then tick toward it
   task automatic match_sequence();
      logic [stcu_pkg::DataWidth-1:0]     start_count;
      logic [stcu_pkg::PrescaleWidth-1:0] pre;
      int ch;
      int steps;
      int ticks;
      ch  = $urandom_range(0, stcu_pkg::MaxChannels - 1);
      pre = ($urandom_range(0, 31) == 0) ? 8'hff
                                         : stcu_pkg::PrescaleWidth'($urandom_range(0, 3));
      steps = $urandom_range(1, 4);
      start_count = ($urandom_range(0, 3) == 0) ? 32'hffffffff - $urandom_range(0, 3)
                                                : $urandom;
      if (pre == 8'hff) steps = 1;
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegControl),
                {16'($urandom_range(0, 65535)), pre, 7'($urandom), 1'b1});
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegCounter), start_count);
      send_item(stcu_pkg::OpWrite, chan_reg(ch, stcu_pkg::OffsetCompare),
                start_count + steps);
      send_item(stcu_pkg::OpWrite, chan_reg(ch, stcu_pkg::OffsetEnable),
                {31'($urandom), 1'($urandom_range(0, 3) != 0)});
      ticks = steps * (int'(pre) + 1) + $urandom_range(0, 2);
      repeat (ticks) begin
         if ($urandom_range(0, 4) == 0) random_read();
         else send_item(stcu_pkg::OpTick, stcu_pkg::IdxWidth'($urandom), $urandom);
      end
      send_item(stcu_pkg::OpRead, chan_reg(ch, stcu_pkg::OffsetFlag), $urandom);
      if ($urandom_range(0, 2) != 0)
         send_item(stcu_pkg::OpWrite, chan_reg(ch, stcu_pkg::OffsetFlag),
                   {31'($urandom), 1'($urandom_range(0, 3) != 0)});
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_item(stcu_pkg::OpRead, stcu_pkg::IdxWidth'(stcu_pkg::RegControl), '0);
      send_item(stcu_pkg::OpWrite, chan_reg(0, stcu_pkg::OffsetCompare), 32'd2);
      send_item(stcu_pkg::OpWrite, chan_reg(0, stcu_pkg::OffsetEnable), 32'hffffffff);
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegControl), 32'h00000001);
      send_item(stcu_pkg::OpTick, '0, '0);
      send_item(stcu_pkg::OpTick, '0, '0);
      send_item(stcu_pkg::OpRead, chan_reg(0, stcu_pkg::OffsetFlag), '0);
      send_item(stcu_pkg::OpWrite, chan_reg(0, stcu_pkg::OffsetFlag), 32'hfffffffe);
      send_item(stcu_pkg::OpWrite, chan_reg(0, stcu_pkg::OffsetFlag), 32'h00000001);
      send_item(2'd3, 4'hf, 32'hffffffff);
      send_item(stcu_pkg::OpRead, 4'he, 32'hffffffff);
      send_item(stcu_pkg::OpWrite, 4'hf, 32'hffffffff);
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegCounter), 32'hffffffff);
      send_item(stcu_pkg::OpWrite, chan_reg(3, stcu_pkg::OffsetCompare), 32'h00000000);
      send_item(stcu_pkg::OpWrite, chan_reg(3, stcu_pkg::OffsetEnable), 32'h00000001);
      send_item(stcu_pkg::OpTick, 4'hf, 32'hffffffff);
      send_item(stcu_pkg::OpRead, chan_reg(3, stcu_pkg::OffsetCompare), '0);
      send_item(stcu_pkg::OpWrite, chan_reg(3, stcu_pkg::OffsetFlag), 32'hffffffff);
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegCounter), 32'h00000000);
      // prescale limit raised, then shrunk below the running prescaler
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegControl), 32'hffffff01);
      send_item(stcu_pkg::OpTick, '0, '0);
      send_item(stcu_pkg::OpTick, '0, '0);
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegControl), 32'h00000101);
      send_item(stcu_pkg::OpTick, '0, '0);
      send_item(stcu_pkg::OpRead, stcu_pkg::IdxWidth'(stcu_pkg::RegCounter), '0);
      send_item(stcu_pkg::OpRead, stcu_pkg::IdxWidth'(stcu_pkg::RegControl), '0);
      send_item(stcu_pkg::OpWrite, stcu_pkg::IdxWidth'(stcu_pkg::RegControl), 32'h00000000);
      send_item(stcu_pkg::OpTick, '0, '0);

      while (items_sent < ItemTarget) begin
         if ($urandom_range(0, 9) < 7) begin
            match_sequence();
         end else begin
            repeat ($urandom_range(1, 6))
               send_item(stcu_pkg::OpWidth'($urandom_range(0, 3)),
                         stcu_pkg::IdxWidth'($urandom_range(0, 15)), $urandom);
         end
      end

      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (sb.failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
